FILE: rtl/core/frf_pkg.sv
// Package for the focal frontier unit: slot word layout, request, status
// and rotation codes, the controller state type, and the sweep control and result types.
// No dependencies; every other file in rtl/core refers to it by scope.
package frf_pkg;

    localparam int KEY_W    = 32;
    localparam int WEIGHT_W = 16;
    // Weight after clamping to 1.0 needs one bit more than the register
    localparam int WEFF_W   = WEIGHT_W + 1;
    localparam int THR_W    = WEFF_W + KEY_W;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] id;
        logic [KEY_W-1:0] f;
        logic [KEY_W-1:0] fhat;
        logic [KEY_W-1:0] dhat;
    } t_slot;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_ERASE  = 2'd1,
        REQ_SELECT = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        STS_OK     = 2'd0,
        STS_EMPTY  = 2'd1,
        STS_FULL   = 2'd2,
        STS_ABSENT = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ROT_DIST = 2'd0,
        ROT_FHAT = 2'd1,
        ROT_F    = 2'd2
    } t_rot;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_A,
        S_MULT,
        S_SCAN_B,
        S_WRITE,
        S_DONE
    } t_state;

    // Sweep control from the sequencer to the scan unit
    typedef struct packed {
        logic start;
        logic pass_b;
        logic rd_vld;
    } t_scan_ctl;

    // Sweep results back to the sequencer
    typedef struct packed {
        logic             match_hit;
        logic             free_hit;
        logic             fmin_hit;
        logic [KEY_W-1:0] fmin;
        logic [KEY_W-1:0] fmin_id;
        logic [KEY_W-1:0] bd_id;
        logic [KEY_W-1:0] bh_id;
    } t_scan_res;

endpackage

FILE: rtl/core/frf_table.sv
// Slot memory of the focal frontier unit: one write port, one read port,
// registered read data. Depends on frf_pkg for the slot word layout.
module frf_table #(
    parameter int  CAPACITY = 64,
    localparam int AddrW    = $clog2(CAPACITY)
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AddrW-1:0]   i_waddr,
    input  frf_pkg::t_slot     i_wdata,
    input  logic [AddrW-1:0]   i_raddr,
    output frf_pkg::t_slot     o_rdata
);

    frf_pkg::t_slot mem [CAPACITY];
    frf_pkg::t_slot r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/frf_scan.sv
// Sweep datapath: folds the slot words read back from the table into the
// id match, first free slot, fmin and the two focal minima. Uses frf_pkg.
module frf_scan #(
    parameter int  CAPACITY         = 64,
    parameter int  WEIGHT_FRAC_BITS = 8,
    localparam int AddrW            = $clog2(CAPACITY)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  frf_pkg::t_scan_ctl                i_ctl,
    input  logic [AddrW-1:0]                  i_rd_idx,
    input  frf_pkg::t_slot                    i_rd_data,
    input  logic [frf_pkg::KEY_W-1:0]         i_key_id,
    input  logic [frf_pkg::THR_W-1:0]         i_thr,
    output frf_pkg::t_scan_res                o_res,
    output logic [AddrW-1:0]                  o_match_idx,
    output logic [AddrW-1:0]                  o_free_idx
);

    logic                         r_match_hit, r_free_hit, r_fmin_hit;
    logic                         r_bd_hit, r_bh_hit;
    logic [AddrW-1:0]             r_match_idx, r_free_idx;
    logic [frf_pkg::KEY_W-1:0]    r_fmin, r_fmin_id;
    logic [frf_pkg::KEY_W-1:0]    r_bd_key, r_bd_id, r_bh_key, r_bh_id;

    logic                         live;
    logic                         focal_ok;
    logic [frf_pkg::THR_W-1:0]    f_scaled;
    logic                         f_better, d_better, h_better;

    // Compare the word on the read port against the running bests
    always_comb begin
        live     = i_ctl.rd_vld && i_rd_data.valid;
        f_scaled = frf_pkg::THR_W'(i_rd_data.f) << WEIGHT_FRAC_BITS;
        focal_ok = (f_scaled <= i_thr);
        f_better = !r_fmin_hit || ({i_rd_data.f, i_rd_data.id} < {r_fmin, r_fmin_id});
        d_better = !r_bd_hit || ({i_rd_data.dhat, i_rd_data.id} < {r_bd_key, r_bd_id});
        h_better = !r_bh_hit || ({i_rd_data.fhat, i_rd_data.id} < {r_bh_key, r_bh_id});
    end

    // Hit flags: drop at the start of each request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.start) begin
            r_match_hit <= 1'b0;
            r_free_hit  <= 1'b0;
            r_fmin_hit  <= 1'b0;
            r_bd_hit    <= 1'b0;
            r_bh_hit    <= 1'b0;
        end else if (!i_ctl.pass_b) begin
            if (live && i_rd_data.id == i_key_id) begin
                r_match_hit <= 1'b1;
            end
            if (i_ctl.rd_vld && !i_rd_data.valid) begin
                r_free_hit <= 1'b1;
            end
            if (live) begin
                r_fmin_hit <= 1'b1;
            end
        end else if (live && focal_ok) begin
            r_bd_hit <= 1'b1;
            r_bh_hit <= 1'b1;
        end
    end

    // Running bests: first sweep for match, free slot and fmin
    always_ff @(posedge i_clk) begin
        if (!i_ctl.pass_b) begin
            if (live && i_rd_data.id == i_key_id && !r_match_hit) begin
                r_match_idx <= i_rd_idx;
            end
            if (i_ctl.rd_vld && !i_rd_data.valid && !r_free_hit) begin
                r_free_idx <= i_rd_idx;
            end
            if (live && f_better) begin
                r_fmin    <= i_rd_data.f;
                r_fmin_id <= i_rd_data.id;
            end
        end else if (live && focal_ok) begin
            // Second sweep: least distance and least f-hat in the focal set
            if (d_better) begin
                r_bd_key <= i_rd_data.dhat;
                r_bd_id  <= i_rd_data.id;
            end
            if (h_better) begin
                r_bh_key <= i_rd_data.fhat;
                r_bh_id  <= i_rd_data.id;
            end
        end
    end

    assign o_res.match_hit = r_match_hit;
    assign o_res.free_hit  = r_free_hit;
    assign o_res.fmin_hit  = r_fmin_hit;
    assign o_res.fmin      = r_fmin;
    assign o_res.fmin_id   = r_fmin_id;
    // The fmin node always lies in the focal set; fall back to it regardless
    assign o_res.bd_id     = r_bd_hit ? r_bd_id : r_fmin_id;
    assign o_res.bh_id     = r_bh_hit ? r_bh_id : r_fmin_id;
    assign o_match_idx     = r_match_idx;
    assign o_free_idx      = r_free_idx;

endmodule

FILE: rtl/core/round_robin_focal_frontier_unit.sv
// Top level of the focal frontier unit: request sequencer, weight register,
// threshold multiplier and result register around frf_table and frf_scan.
// Depends on frf_pkg, frf_table and frf_scan.
//
// A bounded table of search nodes held in a single-port-read slot memory.
// Every request is handled one at a time by sweeping the memory one slot per
// cycle: insert and erase make one sweep to find the id or a free slot, then
// one write; select makes a sweep for fmin, registers the weight times fmin
// product, then makes a sweep for the focal minima; a select on an empty
// table skips the focal sweep, and the unused request code goes straight to
// completion. After reset the unit clears the valid flag of every slot and
// accepts no request word until then; weight writes are taken at any time. A
// finished result waits in the output register while the next request word
// is taken.
module round_robin_focal_frontier_unit #(
    parameter int CAPACITY         = 64,
    parameter int WEIGHT_FRAC_BITS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request stream
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [127:0]                  i_s_tdata,  // node_id, f_key, fhat_key, dist_key
    input  logic [1:0]                    i_s_tuser,  // req_type
    // Result stream
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [31:0]                   o_m_tdata,  // selected_id
    output logic [3:0]                    o_m_tuser,  // status, queue_used
    // Weight register write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [frf_pkg::WEIGHT_W-1:0]  i_cfg_data   // weight_q8
);

    localparam int AddrW = $clog2(CAPACITY);
    localparam logic [AddrW-1:0] LastAddr = AddrW'(CAPACITY - 1);
    localparam logic [frf_pkg::WEFF_W-1:0] WeightOne =
        frf_pkg::WEFF_W'(1) << WEIGHT_FRAC_BITS;

    frf_pkg::t_state              r_state, n_state;
    logic [AddrW-1:0]             r_addr, n_addr;
    logic                         r_issue, n_issue;
    logic                         r_rd_vld, n_rd_vld;
    logic [AddrW-1:0]             r_rd_idx;
    frf_pkg::t_rot                r_phase, n_phase;
    logic [frf_pkg::WEIGHT_W-1:0] r_weight;
    logic [frf_pkg::THR_W-1:0]    r_thr;

    frf_pkg::t_req                r_req;
    logic [frf_pkg::KEY_W-1:0]    r_id, r_f, r_fhat, r_dist;

    logic                         r_out_valid;
    logic [frf_pkg::KEY_W-1:0]    r_out_id, n_out_id;
    frf_pkg::t_status             r_out_sts, n_out_sts;
    frf_pkg::t_rot                r_out_used, n_out_used;

    logic                         s_accept, out_free, load_out;
    logic                         scan_end;
    logic                         mem_we;
    logic [AddrW-1:0]             mem_waddr;
    frf_pkg::t_slot               mem_wdata, mem_rdata;
    frf_pkg::t_scan_ctl           scan_ctl;
    frf_pkg::t_scan_res           scan_res;
    logic [AddrW-1:0]             match_idx, free_idx;
    logic [frf_pkg::WEFF_W-1:0]   weight_eff;
    logic                         sel_ok;

    assign o_s_tready  = (r_state == frf_pkg::S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign out_free    = !r_out_valid || i_m_tready;
    assign load_out    = (r_state == frf_pkg::S_DONE) && out_free;
    assign scan_end    = r_rd_vld && (r_rd_idx == LastAddr);
    assign sel_ok      = (r_req == frf_pkg::REQ_SELECT) && scan_res.fmin_hit;

    // Slot storage
    frf_table #(
        .CAPACITY (CAPACITY)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    assign scan_ctl.start  = s_accept;
    assign scan_ctl.pass_b = (r_state == frf_pkg::S_SCAN_B);
    assign scan_ctl.rd_vld = r_rd_vld;

    // Sweep datapath
    frf_scan #(
        .CAPACITY         (CAPACITY),
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (scan_ctl),
        .i_rd_idx    (r_rd_idx),
        .i_rd_data   (mem_rdata),
        .i_key_id    (r_id),
        .i_thr       (r_thr),
        .o_res       (scan_res),
        .o_match_idx (match_idx),
        .o_free_idx  (free_idx)
    );

    // Memory write: clearing pass, insert or erase; never during a sweep
    always_comb begin
        mem_we          = 1'b0;
        mem_waddr       = r_addr;
        mem_wdata.valid = 1'b0;
        mem_wdata.id    = r_id;
        mem_wdata.f     = r_f;
        mem_wdata.fhat  = r_fhat;
        mem_wdata.dhat  = r_dist;
        if (r_state == frf_pkg::S_CLEAR) begin
            mem_we = 1'b1;
        end else if (r_state == frf_pkg::S_WRITE) begin
            mem_waddr = scan_res.match_hit ? match_idx : free_idx;
            if (r_req == frf_pkg::REQ_INSERT) begin
                mem_we          = scan_res.match_hit || scan_res.free_hit;
                mem_wdata.valid = 1'b1;
            end else begin
                mem_we = scan_res.match_hit;
            end
        end
    end

    // Threshold: weight clamped to 1.0, times fmin
    assign weight_eff = (frf_pkg::WEFF_W'(r_weight) < WeightOne) ?
                        WeightOne : frf_pkg::WEFF_W'(r_weight);

    always_ff @(posedge i_clk) begin
        if (r_state == frf_pkg::S_MULT) begin
            r_thr <= frf_pkg::THR_W'(weight_eff) * frf_pkg::THR_W'(scan_res.fmin);
        end
    end

    // Result of the finished request
    always_comb begin
        n_out_id   = '0;
        n_out_sts  = frf_pkg::STS_OK;
        n_out_used = frf_pkg::ROT_DIST;
        unique case (r_req)
            frf_pkg::REQ_INSERT: begin
                if (!scan_res.match_hit && !scan_res.free_hit) begin
                    n_out_sts = frf_pkg::STS_FULL;
                end
            end
            frf_pkg::REQ_ERASE: begin
                if (!scan_res.match_hit) begin
                    n_out_sts = frf_pkg::STS_ABSENT;
                end
            end
            frf_pkg::REQ_SELECT: begin
                if (!scan_res.fmin_hit) begin
                    n_out_sts = frf_pkg::STS_EMPTY;
                end else begin
                    n_out_used = r_phase;
                    case (r_phase)
                        frf_pkg::ROT_DIST: n_out_id = scan_res.bd_id;
                        frf_pkg::ROT_FHAT: n_out_id = scan_res.bh_id;
                        default:           n_out_id = scan_res.fmin_id;
                    endcase
                end
            end
            default: begin
                n_out_id = '0;
            end
        endcase
    end

    // Next state, sweep address and rotation
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_phase  = r_phase;
        unique case (r_state)
            frf_pkg::S_CLEAR: begin
                n_addr = r_addr + 1'b1;
                if (r_addr == LastAddr) begin
                    n_addr  = '0;
                    n_state = frf_pkg::S_IDLE;
                end
            end
            frf_pkg::S_IDLE: begin
                n_addr  = '0;
                n_issue = 1'b1;
                if (s_accept) begin
                    n_state = (frf_pkg::t_req'(i_s_tuser) == frf_pkg::REQ_NONE) ?
                              frf_pkg::S_DONE : frf_pkg::S_SCAN_A;
                end
            end
            frf_pkg::S_SCAN_A, frf_pkg::S_SCAN_B: begin
                if (r_issue) begin
                    n_rd_vld = 1'b1;
                    n_addr   = r_addr + 1'b1;
                    n_issue  = (r_addr != LastAddr);
                end
                if (scan_end) begin
                    n_addr  = '0;
                    n_issue = 1'b1;
                    if (r_state == frf_pkg::S_SCAN_B) begin
                        n_state = frf_pkg::S_DONE;
                    end else if (r_req != frf_pkg::REQ_SELECT) begin
                        n_state = frf_pkg::S_WRITE;
                    end else begin
                        n_state = frf_pkg::S_MULT;
                    end
                end
            end
            frf_pkg::S_MULT: begin
                // The last swept word has now been folded in; skip the focal
                // sweep when the table is empty
                n_state = scan_res.fmin_hit ? frf_pkg::S_SCAN_B : frf_pkg::S_DONE;
            end
            frf_pkg::S_WRITE: begin
                n_state = frf_pkg::S_DONE;
            end
            frf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = frf_pkg::S_IDLE;
                    if (sel_ok) begin
                        n_phase = (r_phase == frf_pkg::ROT_F) ? frf_pkg::ROT_DIST :
                                  frf_pkg::t_rot'(r_phase + 2'd1);
                    end
                end
            end
            default: begin
                n_state = frf_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= frf_pkg::S_CLEAR;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_phase  <= frf_pkg::ROT_DIST;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_phase  <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
    end

    // Weight register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= frf_pkg::WEIGHT_W'(WeightOne);
        end else if (i_cfg_valid) begin
            r_weight <= i_cfg_data;
        end
    end

    // Hold the accepted request word
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_req  <= frf_pkg::t_req'(i_s_tuser);
            r_id   <= i_s_tdata[31:0];
            r_f    <= i_s_tdata[63:32];
            r_fhat <= i_s_tdata[95:64];
            r_dist <= i_s_tdata[127:96];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_id   <= n_out_id;
            r_out_sts  <= n_out_sts;
            r_out_used <= n_out_used;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_id;
    assign o_m_tuser  = {r_out_used, r_out_sts};

    // Interlock: no table write while a swept word is being consumed
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !r_rd_vld)
        else $error("table written during a sweep");

    // The focal sweep only runs when the first sweep found a node
    a_focal_has_fmin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frf_pkg::S_SCAN_B) |-> scan_res.fmin_hit)
        else $error("focal sweep without fmin");

    // A result appears only from the completion state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> ($past(r_state) == frf_pkg::S_DONE))
        else $error("result raised outside completion");

    // The rotation moves only on a successful select
    a_phase_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != $past(r_phase)) |-> ($past(load_out) && $past(sel_ok)))
        else $error("rotation advanced without a select");

endmodule
